>>> sv/lvm_pkg.sv
// ----------------------------------------------------------------------------
// lvm_pkg
// Shared widths, types and arithmetic helpers of the look-at view matrix unit.
// ----------------------------------------------------------------------------
package lvm_pkg;

  // Coordinate format
  localparam int CW   = 32;             // coordinate width, signed
  localparam int FB   = 16;             // fraction bits
  localparam int TOP  = 29;             // normalised magnitudes sit in [2^TOP, 2^(TOP+1))

  // Unit-length datapath
  localparam int VW   = 49;             // signed lane width of a vector to normalise
  localparam int PW   = $clog2(VW);     // bit index width over a lane
  localparam int SCW  = TOP + 2;        // signed width of a normalised component
  localparam int SQW  = 2 * SCW;        // sum of squares width
  localparam int TW   = SQW + 2;        // square root trial width
  localparam int RTW  = SQW / 2;        // square root width
  localparam int QW   = FB + 1;         // quotient magnitude width
  localparam int UW   = QW + 1;         // signed unit component width
  localparam int DVW  = RTW + FB + 1;   // divider remainder width

  // Matrix back end
  localparam int AW   = UW + 1;         // signed rotation entry width
  localparam int DW   = 40;             // dot product accumulator width

  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  localparam logic [CW-1:0] ONE_Q = CW'(1) << FB;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [2:0][VW-1:0]   vec_t;
  typedef logic [2:0][SCW-1:0]  svec_t;
  typedef logic [2:0][UW-1:0]   uvec_t;

  typedef enum logic [1:0] {
    ROW_SIDE  = 2'd0,
    ROW_UP    = 2'd1,
    ROW_BACK  = 2'd2,
    ROW_CONST = 2'd3
  } row_e;

  // Word carried beside a vector while it is normalised
  typedef struct packed {
    logic               ok;
    logic [2:0][CW-1:0] eye;
    svec_t              us;
    uvec_t              f;
  } lvm_side_t;

  // Round from 2*FB to FB fraction bits, to nearest, ties away from zero
  function automatic logic signed [DW-1:0] rnd_frac(input logic signed [DW-1:0] x);
    logic [DW-1:0] m;
    logic [DW-1:0] half;
    half = DW'(1) << (FB - 1);
    m    = x[DW-1] ? (~x + 1'b1) : x;
    m    = (m + half) >> FB;
    return x[DW-1] ? $signed(~m + 1'b1) : $signed(m);
  endfunction

  // Clamp to the coordinate range
  function automatic coord_t sat_coord(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] cmax;
    logic signed [DW-1:0] cmin;
    cmax = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    cmin = {{(DW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    if (v > cmax) begin
      return cmax[CW-1:0];
    end else if (v < cmin) begin
      return cmin[CW-1:0];
    end else begin
      return v[CW-1:0];
    end
  endfunction

endpackage

>>> sv/lvm_if.sv
// ----------------------------------------------------------------------------
// lvm_if
// Valid/ready channels of the look-at view matrix unit: camera in, rows out.
// ----------------------------------------------------------------------------
interface lvm_in_if;
  import lvm_pkg::*;
  logic   valid;
  logic   ready;
  coord_t eye_x;
  coord_t eye_y;
  coord_t eye_z;
  coord_t target_x;
  coord_t target_y;
  coord_t target_z;
  coord_t up_x;
  coord_t up_y;
  coord_t up_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  up_x, up_y, up_z, input ready);
  modport sink   (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  up_x, up_y, up_z, output ready);
endinterface

interface lvm_out_if;
  import lvm_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] row_index;
  coord_t     col0;
  coord_t     col1;
  coord_t     col2;
  coord_t     col3;
  logic       last;
  logic       degenerate;

  modport source (output valid, row_index, col0, col1, col2, col3, last, degenerate,
                  input ready);
  modport sink   (input valid, row_index, col0, col1, col2, col3, last, degenerate,
                  output ready);
endinterface

>>> sv/lvm_scale.sv
// ----------------------------------------------------------------------------
// lvm_scale
// Three-stage power-of-two scaling of a 3-vector so that its largest
// magnitude lands in [2^TOP, 2^(TOP+1)); magnitudes shift left or right as needed.
// ----------------------------------------------------------------------------
module lvm_scale (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  lvm_pkg::vec_t  vec_i,
  output logic          valid_o,
  output lvm_pkg::svec_t vec_o,
  output logic          nz_o
);
  import lvm_pkg::*;

  localparam logic [PW-1:0] TOP_P = PW'(TOP);

  function automatic logic [PW-1:0] msb_idx(input logic [VW-1:0] x);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < VW; i++) begin
      if (x[i]) p = PW'(i);
    end
    return p;
  endfunction

  logic              v1_q, v2_q, v3_q;
  logic [2:0][VW-1:0] mag1_d, mag1_q, mag2_q;
  logic [2:0]        neg1_d, neg1_q, neg2_q;
  logic [VW-1:0]     or1_q;
  logic [PW-1:0]     p2_q;
  logic              nz2_q, nz3_q;
  svec_t             vec3_d, vec3_q;

  // Take magnitudes and signs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg1_d[i] = vec_i[i][VW-1];
      mag1_d[i] = neg1_d[i] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
  end

  // Shift each magnitude to the common exponent and restore the sign
  always_comb begin
    logic [VW-1:0]  sh;
    logic [SCW-1:0] sm;
    for (int i = 0; i < 3; i++) begin
      sh = (p2_q > TOP_P) ? (mag2_q[i] >> (p2_q - TOP_P)) : (mag2_q[i] << (TOP_P - p2_q));
      sm = {1'b0, sh[TOP:0]};
      vec3_d[i] = neg2_q[i] ? (~sm + 1'b1) : sm;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Advance data: magnitudes, then exponent, then shifted vector
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q <= mag1_d;
      neg1_q <= neg1_d;
      or1_q  <= mag1_d[0] | mag1_d[1] | mag1_d[2];
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
      p2_q   <= msb_idx(or1_q);
      nz2_q  <= |or1_q;
      vec3_q <= vec3_d;
      nz3_q  <= nz2_q;
    end
  end

  assign valid_o = v3_q;
  assign vec_o   = vec3_q;
  assign nz_o    = nz3_q;

endmodule

>>> sv/lvm_unit.sv
// ----------------------------------------------------------------------------
// lvm_unit
// Pipelined unit-length stage: scale, sum of squares, one square root bit per
// stage, then one quotient bit per stage for each of the three lanes.
// ----------------------------------------------------------------------------
module lvm_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  lvm_pkg::vec_t      vec_i,
  input  lvm_pkg::lvm_side_t side_i,
  output logic              valid_o,
  output lvm_pkg::uvec_t     unit_o,
  output logic              nz_o,
  output lvm_pkg::lvm_side_t side_o
);
  import lvm_pkg::*;

  typedef struct packed {
    logic                nz;
    logic [2:0]          neg;
    logic [2:0][TOP:0]   m;
    lvm_side_t           side;
  } ucar_t;

  // Scaling front end, side word delayed to match
  logic      sc_v;
  svec_t     sc_vec;
  logic      sc_nz;
  lvm_side_t side_dl_q [3];

  lvm_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_i),
    .vec_i   (vec_i),
    .valid_o (sc_v),
    .vec_o   (sc_vec),
    .nz_o    (sc_nz)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_dl_q[0] <= side_i;
      side_dl_q[1] <= side_dl_q[0];
      side_dl_q[2] <= side_dl_q[1];
    end
  end

  // Square and sum
  logic               a_v_q, b_v_q;
  ucar_t              a_car_d, a_car_q, b_car_q;
  logic [2:0][SQW-1:0] a_sq_d, a_sq_q;
  logic [SQW-1:0]     b_sum_q;

  always_comb begin
    logic signed [SQW-1:0] sq;
    logic [SCW-1:0]        mg;
    a_car_d.nz   = sc_nz;
    a_car_d.side = side_dl_q[2];
    for (int i = 0; i < 3; i++) begin
      a_car_d.neg[i] = sc_vec[i][SCW-1];
      mg             = sc_vec[i][SCW-1] ? (~sc_vec[i] + 1'b1) : sc_vec[i];
      a_car_d.m[i]   = mg[TOP:0];
      sq             = $signed(sc_vec[i]) * $signed(sc_vec[i]);
      a_sq_d[i]      = sq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= sc_v;
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_car_q <= a_car_d;
      a_sq_q  <= a_sq_d;
      b_car_q <= a_car_q;
      b_sum_q <= a_sq_q[0] + a_sq_q[1] + a_sq_q[2];
    end
  end

  // Square root, one result bit per stage from the top
  logic           sr_v_q    [RTW];
  ucar_t          sr_car_q  [RTW];
  logic [SQW-1:0] sr_rem_q  [RTW];
  logic [RTW-1:0] sr_root_q [RTW];

  for (genvar j = 0; j < RTW; j++) begin : g_sqrt
    localparam int K = RTW - 1 - j;
    logic           v_in;
    ucar_t          car_in;
    logic [SQW-1:0] rem_in;
    logic [RTW-1:0] root_in;
    logic [TW-1:0]  trial;
    logic           ge;

    if (j == 0) begin : g_head
      assign v_in    = b_v_q;
      assign car_in  = b_car_q;
      assign rem_in  = b_sum_q;
      assign root_in = '0;
    end else begin : g_body
      assign v_in    = sr_v_q[j-1];
      assign car_in  = sr_car_q[j-1];
      assign rem_in  = sr_rem_q[j-1];
      assign root_in = sr_root_q[j-1];
    end

    assign trial = ({{(TW-RTW){1'b0}}, root_in} << (K + 1)) | (TW'(1) << (2 * K));
    assign ge    = {{(TW-SQW){1'b0}}, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v_q[j] <= 1'b0;
      end else if (en_i) begin
        sr_v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_car_q[j]  <= car_in;
        sr_rem_q[j]  <= ge ? (rem_in - trial[SQW-1:0]) : rem_in;
        sr_root_q[j] <= ge ? (root_in | (RTW'(1) << K)) : root_in;
      end
    end
  end

  // Divide each lane by the length, one quotient bit per stage
  logic                 dv_v_q   [QW];
  ucar_t                dv_car_q [QW];
  logic [RTW-1:0]       dv_len_q [QW];
  logic [2:0][DVW-1:0]  dv_rem_q [QW];
  logic [2:0][QW-1:0]   dv_quo_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    logic                v_in;
    ucar_t               car_in;
    logic [RTW-1:0]      len_in;
    logic [2:0][DVW-1:0] rem_in, rem_d;
    logic [2:0][QW-1:0]  quo_in, quo_d;
    logic [DVW-1:0]      dvs;

    if (j == 0) begin : g_head
      assign v_in   = sr_v_q[RTW-1];
      assign car_in = sr_car_q[RTW-1];
      assign len_in = sr_root_q[RTW-1];
      assign quo_in = '0;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = {{(DVW-TOP-1-FB){1'b0}}, car_in.m[i], {FB{1'b0}}};
      end
    end else begin : g_body
      assign v_in   = dv_v_q[j-1];
      assign car_in = dv_car_q[j-1];
      assign len_in = dv_len_q[j-1];
      assign rem_in = dv_rem_q[j-1];
      assign quo_in = dv_quo_q[j-1];
    end

    assign dvs = {{(DVW-RTW){1'b0}}, len_in} << K;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= dvs) begin
          rem_d[i] = rem_in[i] - dvs;
          quo_d[i] = quo_in[i] | (QW'(1) << K);
        end else begin
          rem_d[i] = rem_in[i];
          quo_d[i] = quo_in[i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_car_q[j] <= car_in;
        dv_len_q[j] <= len_in;
        dv_rem_q[j] <= rem_d;
        dv_quo_q[j] <= quo_d;
      end
    end
  end

  // Restore signs on the quotients
  always_comb begin
    logic [UW-1:0] qm;
    for (int i = 0; i < 3; i++) begin
      qm        = {1'b0, dv_quo_q[QW-1][i]};
      unit_o[i] = dv_car_q[QW-1].neg[i] ? (~qm + 1'b1) : qm;
    end
  end

  assign valid_o = dv_v_q[QW-1];
  assign nz_o    = dv_car_q[QW-1].nz;
  assign side_o  = dv_car_q[QW-1].side;

endmodule

>>> sv/look_at_view_matrix_unit.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// Look-at view matrix generator in signed Q16.16, four rows per camera word.
// ----------------------------------------------------------------------------
// One camera word (eye, target, up hint) yields four row words, rows 0 to 3,
// with last on row 3. The datapath is a single stall-on-full pipeline of
// about 117 stages: two unit-length sections (53 stages each: scaling,
// squares, one square root bit per stage, one quotient bit per stage), the
// cross products, and five stages for the new up vector and the eye dot
// products. A row serialiser behind it sends one row per cycle while
// row_o.ready is high, and the row port, which carries four rows for
// each camera word, sets the sustained rate of camera words.
// A zero forward or side vector gives zero rows 0 to 2 and raises
// degenerate on all four rows; row 3 is always 0, 0, 0, 1.0.
module look_at_view_matrix_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  lvm_in_if.sink     item_i,
  lvm_out_if.source  row_o
);
  import lvm_pkg::*;

  function automatic logic [VW-1:0] sext_vw(input logic [CW-1:0] x);
    return {{(VW-CW){x[CW-1]}}, x};
  endfunction

  function automatic coord_t ext_aw(input logic [AW-1:0] x);
    return {{(CW-AW){x[AW-1]}}, x};
  endfunction

  logic en;

  // --------------------------------------------------------------------------
  // Input stage: forward difference
  // --------------------------------------------------------------------------
  logic [2:0][CW-1:0] in_eye, in_tgt, in_up;
  logic               v1_q;
  logic [2:0][CW-1:0] eye1_q;
  vec_t               d1_q, uh1_q;

  assign in_eye = {item_i.eye_z, item_i.eye_y, item_i.eye_x};
  assign in_tgt = {item_i.target_z, item_i.target_y, item_i.target_x};
  assign in_up  = {item_i.up_z, item_i.up_y, item_i.up_x};

  assign item_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      eye1_q <= in_eye;
      for (int i = 0; i < 3; i++) begin
        d1_q[i]  <= sext_vw(in_tgt[i]) - sext_vw(in_eye[i]);
        uh1_q[i] <= sext_vw(in_up[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scale the up hint while the forward vector waits
  // --------------------------------------------------------------------------
  logic               up_v;
  svec_t              up_s;
  logic [2:0][CW-1:0] eye_dl_q [3];
  vec_t               d_dl_q   [3];

  lvm_scale u_up_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .vec_i   (uh1_q),
    .valid_o (up_v),
    .vec_o   (up_s),
    .nz_o    ()
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      eye_dl_q[0] <= eye1_q;
      eye_dl_q[1] <= eye_dl_q[0];
      eye_dl_q[2] <= eye_dl_q[1];
      d_dl_q[0]   <= d1_q;
      d_dl_q[1]   <= d_dl_q[0];
      d_dl_q[2]   <= d_dl_q[1];
    end
  end

  // --------------------------------------------------------------------------
  // Forward unit vector
  // --------------------------------------------------------------------------
  lvm_side_t side1_in, side1_out;
  logic      u1_v, u1_nz;
  uvec_t     u1_f;

  always_comb begin
    side1_in     = '0;
    side1_in.ok  = 1'b1;
    side1_in.eye = eye_dl_q[2];
    side1_in.us  = up_s;
  end

  lvm_unit u_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (up_v),
    .vec_i   (d_dl_q[2]),
    .side_i  (side1_in),
    .valid_o (u1_v),
    .unit_o  (u1_f),
    .nz_o    (u1_nz),
    .side_o  (side1_out)
  );

  // --------------------------------------------------------------------------
  // Side cross product: products, then differences
  // --------------------------------------------------------------------------
  logic               v2_q, v3_q;
  lvm_side_t          sd2_d, sd2_q, sd3_q;
  logic signed [VW-1:0] pa2_q [3];
  logic signed [VW-1:0] pb2_q [3];
  vec_t               c3_q;

  // Attach the forward unit vector and its validity to the side word
  always_comb begin
    sd2_d    = side1_out;
    sd2_d.ok = side1_out.ok & u1_nz;
    sd2_d.f  = u1_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v2_q <= u1_v;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd2_q <= sd2_d;
      for (int i = 0; i < 3; i++) begin
        pa2_q[i] <= $signed(u1_f[NXT[i]]) * $signed(side1_out.us[PRV[i]]);
        pb2_q[i] <= $signed(u1_f[PRV[i]]) * $signed(side1_out.us[NXT[i]]);
      end
      sd3_q <= sd2_q;
      for (int i = 0; i < 3; i++) begin
        c3_q[i] <= pa2_q[i] - pb2_q[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Side unit vector
  // --------------------------------------------------------------------------
  lvm_side_t side2_out;
  logic      u2_v, u2_nz;
  uvec_t     u2_s;

  lvm_unit u_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .vec_i   (c3_q),
    .side_i  (sd3_q),
    .valid_o (u2_v),
    .unit_o  (u2_s),
    .nz_o    (u2_nz),
    .side_o  (side2_out)
  );

  // --------------------------------------------------------------------------
  // New up vector: products, then rounded differences
  // --------------------------------------------------------------------------
  logic                   v4_q, v5_q;
  logic                   ok4_q, ok5_q;
  logic [2:0][CW-1:0]     eye4_q, eye5_q;
  uvec_t                  s4_q, f4_q, s5_q, f5_q;
  logic signed [2*UW-1:0] pa4_q [3];
  logic signed [2*UW-1:0] pb4_q [3];
  logic signed [AW-1:0]   u5_d  [3];
  logic signed [AW-1:0]   u5_q  [3];

  always_comb begin
    logic signed [DW-1:0] df;
    logic signed [DW-1:0] rd;
    for (int i = 0; i < 3; i++) begin
      df      = pa4_q[i] - pb4_q[i];
      rd      = rnd_frac(df);
      u5_d[i] = rd[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v4_q <= u2_v;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok4_q  <= side2_out.ok & u2_nz;
      eye4_q <= side2_out.eye;
      s4_q   <= u2_s;
      f4_q   <= side2_out.f;
      for (int i = 0; i < 3; i++) begin
        pa4_q[i] <= $signed(u2_s[NXT[i]]) * $signed(side2_out.f[PRV[i]]);
        pb4_q[i] <= $signed(u2_s[PRV[i]]) * $signed(side2_out.f[NXT[i]]);
      end
      ok5_q  <= ok4_q;
      eye5_q <= eye4_q;
      s5_q   <= s4_q;
      f5_q   <= f4_q;
      u5_q   <= u5_d;
    end
  end

  // --------------------------------------------------------------------------
  // Eye dot products: whole and fraction parts of the eye kept apart
  // --------------------------------------------------------------------------
  logic                 v6_q, v7_q;
  logic                 ok6_q, ok7_q;
  logic signed [AW-1:0] av    [3][3];
  logic signed [AW-1:0] rot6_q [3][3];
  logic signed [AW-1:0] rot7_q [3][3];
  logic signed [DW-1:0] wh6_q [3][3];
  logic signed [DW-1:0] pt6_q [3][3];
  logic signed [DW-1:0] ws7_q [3];
  logic signed [DW-1:0] ps7_q [3];
  logic signed [CW-FB-1:0] e_hi [3];
  logic signed [FB:0]      e_lo [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      av[0][i] = AW'($signed(s5_q[i]));
      av[1][i] = u5_q[i];
      av[2][i] = AW'($signed(f5_q[i]));
      e_hi[i]  = $signed(eye5_q[i][CW-1:FB]);
      e_lo[i]  = $signed({1'b0, eye5_q[i][FB-1:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok6_q <= ok5_q;
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          wh6_q[r][i] <= av[r][i] * e_hi[i];
          pt6_q[r][i] <= av[r][i] * e_lo[i];
        end
      end
      rot6_q[0] <= av[0];
      rot6_q[1] <= av[1];
      for (int i = 0; i < 3; i++) begin
        rot6_q[2][i] <= -av[2][i];
      end
      ok7_q  <= ok6_q;
      rot7_q <= rot6_q;
      for (int r = 0; r < 3; r++) begin
        ws7_q[r] <= wh6_q[r][0] + wh6_q[r][1] + wh6_q[r][2];
        ps7_q[r] <= pt6_q[r][0] + pt6_q[r][1] + pt6_q[r][2];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result stage: translation, saturation, degenerate zeroing
  // --------------------------------------------------------------------------
  logic   r_v_q;
  logic   r_degen_q;
  coord_t r_rows_d [3][4];
  coord_t r_rows_q [3][4];

  always_comb begin
    logic signed [DW-1:0] t;
    for (int r = 0; r < 3; r++) begin
      t = ws7_q[r] + rnd_frac(ps7_q[r]);
      if (r != 2) t = -t;
      for (int i = 0; i < 3; i++) begin
        r_rows_d[r][i] = ok7_q ? ext_aw(rot7_q[r][i]) : '0;
      end
      r_rows_d[r][3] = ok7_q ? sat_coord(t) : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Row serialiser: one row word per cycle while row_o.ready is high, reloads on the last row
  // --------------------------------------------------------------------------
  logic   b_v_q;
  row_e   row_q;
  logic   degen_q;
  coord_t rows_q [4][4];
  logic   load;

  assign load = r_v_q && (!b_v_q || (row_o.ready && row_q == ROW_CONST));
  assign en   = !r_v_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
    end else if (en) begin
      r_v_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_rows_q  <= r_rows_d;
      r_degen_q <= !ok7_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      row_q <= ROW_SIDE;
    end else if (load) begin
      b_v_q <= 1'b1;
      row_q <= ROW_SIDE;
    end else if (b_v_q && row_o.ready) begin
      if (row_q == ROW_CONST) begin
        b_v_q <= 1'b0;
      end else begin
        row_q <= row_e'(row_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rows_q[0] <= r_rows_q[0];
      rows_q[1] <= r_rows_q[1];
      rows_q[2] <= r_rows_q[2];
      rows_q[3] <= '{'0, '0, '0, ONE_Q};
      degen_q   <= r_degen_q;
    end
  end

  assign row_o.valid      = b_v_q;
  assign row_o.row_index  = row_q;
  assign row_o.col0       = rows_q[row_q][0];
  assign row_o.col1       = rows_q[row_q][1];
  assign row_o.col2       = rows_q[row_q][2];
  assign row_o.col3       = rows_q[row_q][3];
  assign row_o.last       = (row_q == ROW_CONST);
  assign row_o.degenerate = degen_q;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the look-at view matrix unit: a short table of
// camera words, then random ones, each predicted row compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import lvm_pkg::*;

  localparam int     LIMIT      = 400000;  // cycles before the run is abandoned
  localparam int     N_RANDOM   = 480;
  localparam int     LONG_HOLD  = 600;     // row port held off, well past pipeline depth
  localparam int     DRAIN_WAIT = 300;
  localparam coord_t CMAX       = 32'sh7fff_ffff;
  localparam coord_t CMIN       = 32'sh8000_0000;
  localparam coord_t Q1         = 32'sh0001_0000;

  typedef longint          lvec_t [3];
  typedef longint unsigned umag_t;

  typedef struct packed {
    coord_t ex, ey, ez;
    coord_t tx, ty, tz;
    coord_t ux, uy, uz;
  } camera_t;

  // Directed row: camera word plus whether its matrix is the degenerate one
  typedef struct packed {
    camera_t cam;
    logic    deg;
  } cam_row_t;

  typedef struct packed {
    logic [1:0] row_index;
    coord_t     col0, col1, col2, col3;
    logic       last;
    logic       degenerate;
  } mat_row_t;

  logic clk_i;
  logic rst_ni;

  lvm_in_if  item_if ();
  lvm_out_if row_if ();

  look_at_view_matrix_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .row_o  (row_if)
  );

  mat_row_t pending_rows [$];
  int       fail_count  = 0;
  int       cycle_count = 0;
  int       words_sent  = 0;
  int       rows_seen   = 0;
  int       degen_seen  = 0;
  bit       hold_req    = 0;
  bit       calm        = 0;

  // Clock and reset
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Abandon the run at the cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic umag_t mag64(input longint v);
    return (v < 0) ? umag_t'(-v) : umag_t'(v);
  endfunction

  // Drop FB fraction bits, nearest, ties away from zero
  function automatic longint round_q(input longint x);
    umag_t m;
    m = (mag64(x) + (64'd1 << (FB - 1))) >> FB;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic coord_t clamp_coord(input longint v);
    if (v > longint'(CMAX)) return CMAX;
    if (v < longint'(CMIN)) return CMIN;
    return coord_t'(v);
  endfunction

  // Shift so the largest magnitude lands in [2^TOP, 2^(TOP+1))
  function automatic bit scale_vec(input lvec_t v, output lvec_t o);
    umag_t m [3];
    umag_t mx, s;
    int    p;
    mx = 0;
    p  = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag64(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return 1'b0;
    end
    while (p < 63 && (mx >> (p + 1)) != 0) p++;
    for (int i = 0; i < 3; i++) begin
      s    = (p > TOP) ? (m[i] >> (p - TOP)) : (m[i] << (TOP - p));
      o[i] = (v[i] < 0) ? -longint'(s) : longint'(s);
    end
    return 1'b1;
  endfunction

  function automatic umag_t root_floor(input umag_t n);
    umag_t r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit make_unit(input lvec_t v, output lvec_t o);
    lvec_t t;
    umag_t sum, len, q;
    sum = 0;
    if (!scale_vec(v, t)) begin
      o = '{0, 0, 0};
      return 1'b0;
    end
    for (int i = 0; i < 3; i++) sum += mag64(t[i]) * mag64(t[i]);
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q    = (mag64(t[i]) << FB) / len;
      o[i] = (t[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  // Rotation row dotted with the eye, split into whole and fraction parts
  function automatic longint dot_with_eye(input lvec_t a, input lvec_t e);
    longint whole, part, lo, hi;
    whole = 0;
    part  = 0;
    for (int i = 0; i < 3; i++) begin
      lo    = e[i] & ((64'd1 << FB) - 1);
      hi    = (e[i] - lo) / (64'sd1 <<< FB);
      whole += a[i] * hi;
      part  += a[i] * lo;
    end
    return whole + round_q(part);
  endfunction

  function automatic mat_row_t pack_row(input int r, input longint c0, input longint c1,
                                        input longint c2, input longint c3, input bit deg);
    mat_row_t w;
    w.row_index  = 2'(r);
    w.col0       = clamp_coord(c0);
    w.col1       = clamp_coord(c1);
    w.col2       = clamp_coord(c2);
    w.col3       = clamp_coord(c3);
    w.last       = (r == ROW_CONST);
    w.degenerate = deg;
    return w;
  endfunction

  // Push the four rows of a degenerate matrix
  task automatic push_degenerate();
    for (int r = ROW_SIDE; r <= ROW_BACK; r++) pending_rows.push_back(pack_row(r, 0, 0, 0, 0, 1));
    pending_rows.push_back(pack_row(ROW_CONST, 0, 0, 0, longint'(Q1), 1));
  endtask

  // Work out the view matrix of one camera word and queue its rows
  task automatic predict_matrix(input camera_t c);
    lvec_t eye, dir, uh, us, fwd, cr, side, nup;
    bit    ok;
    eye = '{longint'(c.ex), longint'(c.ey), longint'(c.ez)};
    dir = '{longint'(c.tx) - eye[0], longint'(c.ty) - eye[1], longint'(c.tz) - eye[2]};
    uh  = '{longint'(c.ux), longint'(c.uy), longint'(c.uz)};
    ok  = make_unit(dir, fwd);
    if (ok) begin
      void'(scale_vec(uh, us));
      cr[0] = fwd[1] * us[2] - fwd[2] * us[1];
      cr[1] = fwd[2] * us[0] - fwd[0] * us[2];
      cr[2] = fwd[0] * us[1] - fwd[1] * us[0];
      ok    = make_unit(cr, side);
    end
    if (!ok) begin
      push_degenerate();
    end else begin
      nup[0] = round_q(side[1] * fwd[2] - side[2] * fwd[1]);
      nup[1] = round_q(side[2] * fwd[0] - side[0] * fwd[2]);
      nup[2] = round_q(side[0] * fwd[1] - side[1] * fwd[0]);
      pending_rows.push_back(pack_row(ROW_SIDE, side[0], side[1], side[2],
                                      -dot_with_eye(side, eye), 0));
      pending_rows.push_back(pack_row(ROW_UP, nup[0], nup[1], nup[2],
                                      -dot_with_eye(nup, eye), 0));
      pending_rows.push_back(pack_row(ROW_BACK, -fwd[0], -fwd[1], -fwd[2],
                                      dot_with_eye(fwd, eye), 0));
      pending_rows.push_back(pack_row(ROW_CONST, 0, 0, 0, longint'(Q1), 0));
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic coord_t rand_coord();
    return coord_t'($urandom) >>> $urandom_range(0, 24);
  endfunction

  function automatic camera_t rand_camera();
    camera_t c;
    int      ax;
    c  = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
          rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    ax = $urandom_range(0, 2);
    case ($urandom_range(0, 11))
      0: begin
        // full-range noise
        c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
      end
      1: begin
        // target on the eye
        {c.tx, c.ty, c.tz} = {c.ex, c.ey, c.ez};
      end
      2: begin
        // view direction and up hint on one axis
        {c.tx, c.ty, c.tz} = {c.ex, c.ey, c.ez};
        {c.ux, c.uy, c.uz} = '0;
        case (ax)
          0: begin c.tx = c.ex + rand_coord(); c.ux = rand_coord(); end
          1: begin c.ty = c.ey + rand_coord(); c.uy = rand_coord(); end
          default: begin c.tz = c.ez + rand_coord(); c.uz = rand_coord(); end
        endcase
      end
      3: begin
        // no up hint
        {c.ux, c.uy, c.uz} = '0;
      end
      default: ;
    endcase
    return c;
  endfunction

  cam_row_t dir_tab [$];

  task automatic offer_word(input camera_t c);
    item_if.valid    <= 1'b1;
    item_if.eye_x    <= c.ex;
    item_if.eye_y    <= c.ey;
    item_if.eye_z    <= c.ez;
    item_if.target_x <= c.tx;
    item_if.target_y <= c.ty;
    item_if.target_z <= c.tz;
    item_if.up_x     <= c.ux;
    item_if.up_y     <= c.uy;
    item_if.up_z     <= c.uz;
    do @(posedge clk_i); while (!item_if.ready);
    words_sent++;
  endtask

  // Now and then, unless calm, drop valid for a burst of random length
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  initial begin
    camera_t c;
    {item_if.valid, item_if.eye_x, item_if.eye_y, item_if.eye_z, item_if.target_x,
     item_if.target_y, item_if.target_z, item_if.up_x, item_if.up_y, item_if.up_z} = '0;

    // eye, target, up, degenerate
    dir_tab.push_back('{'{0, 0, 0, 0, 0, -Q1, 0, Q1, 0}, 1'b0});
    dir_tab.push_back('{'{Q1, 2*Q1, 3*Q1, Q1, 2*Q1, 3*Q1, 0, Q1, 0}, 1'b1});
    dir_tab.push_back('{'{0, 0, 0, 0, 5*Q1, 0, 0, Q1, 0}, 1'b1});
    dir_tab.push_back('{'{0, 0, 0, Q1, Q1, Q1, 0, 0, 0}, 1'b1});
    dir_tab.push_back('{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1});
    dir_tab.push_back('{'{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, Q1, 0}, 1'b0});
    dir_tab.push_back('{'{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, 0, CMAX}, 1'b0});
    dir_tab.push_back('{'{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0});
    dir_tab.push_back('{'{CMIN, 0, 0, CMAX, 0, 0, CMIN, 0, 0}, 1'b1});
    dir_tab.push_back('{'{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1'b0});
    dir_tab.push_back('{'{0, 0, 0, 0, 0, -1, 0, 0, -1}, 1'b1});
    dir_tab.push_back('{'{3*Q1, -7*Q1, 11*Q1, 0, 0, 0, 0, 0, Q1}, 1'b0});
    dir_tab.push_back('{'{-1, -1, -1, 1, 1, 1, 1, -1, 0}, 1'b0});
    dir_tab.push_back('{'{CMAX, CMAX, CMAX, CMAX - 1, CMAX, CMAX, 0, CMIN, 0}, 1'b0});
    dir_tab.push_back('{'{Q1/2, -Q1/2, Q1/2, -Q1/2, Q1/2, -Q1/2, Q1, Q1, 0}, 1'b0});

    @(posedge clk_i iff rst_ni);

    foreach (dir_tab[i]) begin
      offer_word(dir_tab[i].cam);
      if (dir_tab[i].deg) push_degenerate();
      else predict_matrix(dir_tab[i].cam);
      maybe_gap();
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // fill the pipeline against a held-off row port
      if (n == 120) hold_req = 1;
      // let every outstanding row drain before going on
      if (n == 300) begin
        item_if.valid <= 1'b0;
        wait (pending_rows.size() == 0);
        @(posedge clk_i);
      end
      if (n == N_RANDOM - 60) calm = 1;
      c = rand_camera();
      offer_word(c);
      predict_matrix(c);
      maybe_gap();
    end
    item_if.valid <= 1'b0;

    wait (pending_rows.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_rows.size() != 0) begin
      $error("%0d matrix rows never arrived", pending_rows.size());
      fail_count++;
    end
    $display("Sent %0d camera words, checked %0d rows (%0d degenerate)",
             words_sent, rows_seen, degen_seen);
    $display("Covered extremes, degenerate views, back-pressure and a full drain");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- row port

  task automatic check_row();
    mat_row_t want;
    if (pending_rows.size() == 0) begin
      $error("row word with none expected");
      fail_count++;
      return;
    end
    want = pending_rows.pop_front();
    rows_seen++;
    if (row_if.degenerate) degen_seen++;
    if (row_if.row_index !== want.row_index) begin
      $error("row_index: expected %0d, got %0d", want.row_index, row_if.row_index);
      fail_count++;
    end
    if (row_if.col0 !== want.col0) begin
      $error("col0: expected %0d, got %0d", want.col0, row_if.col0);
      fail_count++;
    end
    if (row_if.col1 !== want.col1) begin
      $error("col1: expected %0d, got %0d", want.col1, row_if.col1);
      fail_count++;
    end
    if (row_if.col2 !== want.col2) begin
      $error("col2: expected %0d, got %0d", want.col2, row_if.col2);
      fail_count++;
    end
    if (row_if.col3 !== want.col3) begin
      $error("col3: expected %0d, got %0d", want.col3, row_if.col3);
      fail_count++;
    end
    if (row_if.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, row_if.last);
      fail_count++;
    end
    if (row_if.degenerate !== want.degenerate) begin
      $error("degenerate: expected %0b, got %0b", want.degenerate, row_if.degenerate);
      fail_count++;
    end
  endtask

  // Take row words, stalling in bursts or for one long hold
  initial begin
    int  hold_left;
    int  stall_left;
    bit  rdy;
    hold_left     = 0;
    stall_left    = 0;
    row_if.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && row_if.valid && row_if.ready) check_row();
      if (hold_req) begin
        hold_req  = 0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (calm) begin
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if ($urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        rdy        = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      row_if.ready <= rdy;
    end
  end

endmodule

>>> filelist.f
sv/lvm_pkg.sv
sv/lvm_if.sv
sv/lvm_scale.sv
sv/lvm_unit.sv
sv/look_at_view_matrix_unit.sv
tb/tb.sv
